@@ hdl/mcpf_pkg.sv @@
package mcpf_pkg;

  localparam int PIPE_ID_W = 4;
  localparam int MAX_IDS   = 16;
  localparam int QDEPTH    = 4;
  localparam int QPW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_ALLOC    = 3'd0,
    MODE_WRITE    = 3'd1,
    MODE_READ     = 3'd2,
    MODE_CLOSE_RD = 3'd3,
    MODE_CLOSE_WR = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NO_FREE = 2'd3
  } status_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic [PIPE_ID_W-1:0] grant;
    logic                 eor;
    logic                 rd_ok;
  } fe_stage_t;

  typedef struct packed {
    status_t              status;
    logic [7:0]           data;
    logic [PIPE_ID_W-1:0] grant;
    logic                 eor;
  } result_t;

endpackage

@@ hdl/mcpf_if.sv @@
interface mcpf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] pipe_id;
  logic [7:0] data_in;
  logic       end_of_request;

  modport source (output valid, mode, pipe_id, data_in, end_of_request, input ready);
  modport sink   (input valid, mode, pipe_id, data_in, end_of_request, output ready);
endinterface

interface mcpf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_out;
  logic [3:0] granted_pipe;
  logic       request_done;

  modport source (output valid, status, data_out, granted_pipe, request_done, input ready);
  modport sink   (input valid, status, data_out, granted_pipe, request_done, output ready);
endinterface

@@ hdl/mcpf_ram.sv @@
module mcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/mcpf_front.sv @@
module mcpf_front
  import mcpf_pkg::*;
#(
  parameter int NUM_PIPES  = 16,
  parameter int PIPE_BYTES = 512,
  localparam int NID = (NUM_PIPES < MAX_IDS) ? NUM_PIPES : MAX_IDS,
  localparam int AW  = (NID * PIPE_BYTES > 1) ? $clog2(NID * PIPE_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  mcpf_in_if.sink       op,
  input  logic [QCW-1:0] level,
  output fe_stage_t     st,
  output logic          ram_we,
  output logic [AW-1:0] ram_addr,
  output logic [7:0]    ram_wdata
);

  localparam int IW      = (NID > 1) ? $clog2(NID) : 1;
  localparam int SW      = $clog2(PIPE_BYTES);
  localparam int CW      = $clog2(2 * PIPE_BYTES);
  localparam int CNT_MOD = 2 * PIPE_BYTES;
  localparam int PW1     = PIPE_ID_W + 1;

  logic [CW-1:0] rcnt [NID];
  logic [CW-1:0] wcnt [NID];
  logic [NID-1:0] rd_open;
  logic [NID-1:0] wr_open;

  logic          acc;
  logic          present;
  logic [IW-1:0] idx;
  logic [CW-1:0] wc, rc, occ, cnt_sel;
  logic [SW-1:0] slot;
  logic          full, empty;
  logic          any_free;
  logic [IW-1:0] gidx;
  logic          do_write, do_read, do_alloc;
  fe_stage_t     st_next;

  assign acc     = op.valid && op.ready;
  assign op.ready = (QCW'(level) + QCW'(st.valid)) < QCW'(QDEPTH);

  assign present = PW1'(op.pipe_id) < PW1'(NID);
  assign idx     = op.pipe_id[IW-1:0];
  assign wc      = wcnt[idx];
  assign rc      = rcnt[idx];
  assign occ     = (wc >= rc) ? (wc - rc) : (wc - rc + CW'(CNT_MOD));
  assign full    = occ >= CW'(PIPE_BYTES);
  assign empty   = occ == '0;

  assign cnt_sel   = (op.mode == MODE_WRITE) ? wc : rc;
  assign slot      = (cnt_sel >= CW'(PIPE_BYTES)) ? SW'(cnt_sel - CW'(PIPE_BYTES)) : SW'(cnt_sel);
  assign ram_addr  = AW'(idx) * AW'(PIPE_BYTES) + AW'(slot);
  assign ram_wdata = op.data_in;
  assign ram_we    = acc && do_write;

  always_comb begin
    any_free = 1'b0;
    gidx     = '0;
    for (int i = NID - 1; i >= 0; i--) begin
      if (!rd_open[i] && !wr_open[i]) begin
        any_free = 1'b1;
        gidx     = IW'(i);
      end
    end
  end

  always_comb begin
    do_write      = 1'b0;
    do_read       = 1'b0;
    do_alloc      = 1'b0;
    st_next.valid = acc;
    st_next.status = ST_OK;
    st_next.grant = '0;
    st_next.eor   = op.end_of_request;
    st_next.rd_ok = 1'b0;
    case (op.mode)
      MODE_ALLOC: begin
        if (any_free) begin
          do_alloc      = 1'b1;
          st_next.grant = PIPE_ID_W'(gidx);
        end else begin
          st_next.status = ST_NO_FREE;
        end
      end
      MODE_WRITE: begin
        if (!present || full) begin
          st_next.status = ST_FULL;
        end else begin
          do_write = 1'b1;
        end
      end
      MODE_READ: begin
        if (!present || empty) begin
          st_next.status = ST_EMPTY;
        end else begin
          do_read       = 1'b1;
          st_next.rd_ok = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
      rd_open  <= '0;
      wr_open  <= '0;
      for (int i = 0; i < NID; i++) begin
        rcnt[i] <= '0;
        wcnt[i] <= '0;
      end
    end else begin
      st <= st_next;
      if (acc) begin
        case (op.mode)
          MODE_ALLOC: begin
            if (do_alloc) begin
              rcnt[gidx]    <= '0;
              wcnt[gidx]    <= '0;
              rd_open[gidx] <= 1'b1;
              wr_open[gidx] <= 1'b1;
            end
          end
          MODE_WRITE: begin
            if (do_write) begin
              wcnt[idx] <= (wc == CW'(CNT_MOD - 1)) ? '0 : wc + 1'b1;
            end
          end
          MODE_READ: begin
            if (do_read) begin
              rcnt[idx] <= (rc == CW'(CNT_MOD - 1)) ? '0 : rc + 1'b1;
            end
          end
          MODE_CLOSE_RD: begin
            if (present) begin
              rd_open[idx] <= 1'b0;
            end
          end
          MODE_CLOSE_WR: begin
            if (present) begin
              wr_open[idx] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_acc_staged: assert property (@(posedge clk) disable iff (rst)
    acc |=> st.valid)
    else $error("accepted transfer not staged");

  a_rd_ok_status: assert property (@(posedge clk) disable iff (rst)
    (st.valid && st.rd_ok) |-> (st.status == ST_OK))
    else $error("read data flagged on failed read");

endmodule

@@ hdl/mcpf_back.sv @@
module mcpf_back
  import mcpf_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  fe_stage_t      st,
  input  logic [7:0]     rdata,
  output logic [QCW-1:0] level,
  mcpf_out_if.source     res
);

  result_t        q [QDEPTH];
  logic [QPW-1:0] wptr, rptr;
  logic [QCW-1:0] count;
  logic           push, pop;
  result_t        entry;
  result_t        head;

  assign push  = st.valid;
  assign pop   = res.valid && res.ready;
  assign level = count;

  assign entry.status = st.status;
  assign entry.data   = st.rd_ok ? rdata : '0;
  assign entry.grant  = st.grant;
  assign entry.eor    = st.eor;

  assign head             = q[rptr];
  assign res.valid        = count != '0;
  assign res.status       = head.status;
  assign res.data_out     = head.data;
  assign res.granted_pipe = head.grant;
  assign res.request_done = head.eor;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCW'(QDEPTH)))
    else $error("result queue overflow");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("result queue level out of range");

endmodule

@@ hdl/multi_channel_pipe_fifo.sv @@
// Table of byte pipes, each a ring buffer in a shared byte store with its own read and write
// counters and open flags. Every transfer on op is one operation (allocate, write byte, read
// byte, close read end, close write end) and yields exactly one transfer on res, in order.
// One operation per cycle is sustained while res takes results; a result is first offered
// once it has passed the registered read port of the byte store, alongside the staged
// operation, and then the write into the result queue. A four-entry result queue decouples
// the classifying front from the output, so op keeps flowing while res is stalled until the
// queue fills. The byte store has no reset or clearing pass: it is used as soon as reset ends.
module multi_channel_pipe_fifo
  import mcpf_pkg::*;
#(
  parameter int NUM_PIPES  = 16,
  parameter int PIPE_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  mcpf_in_if.sink    op,
  mcpf_out_if.source res
);

  localparam int NID   = (NUM_PIPES < MAX_IDS) ? NUM_PIPES : MAX_IDS;
  localparam int DEPTH = NID * PIPE_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fe_stage_t      st;
  logic [QCW-1:0] level;
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;

  mcpf_front #(
    .NUM_PIPES  (NUM_PIPES),
    .PIPE_BYTES (PIPE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .level     (level),
    .st        (st),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata)
  );

  mcpf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  mcpf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .st    (st),
    .rdata (ram_rdata),
    .level (level),
    .res   (res)
  );

endmodule
